// File: rtl/gdconv_pkg.sv
// Shared types, constants and calendar tables for the date / day-number converter.
`timescale 1ns / 1ps
package gdconv_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned SerialW = 22;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned SumW    = SerialW + 1;

  localparam int unsigned BASE_YEAR = 1601;
  localparam int unsigned MAX_YEAR  = 9999;

  localparam logic [YearW-1:0] BaseYearW = YearW'(BASE_YEAR);
  localparam logic [YearW-1:0] MaxYearW  = YearW'(MAX_YEAR);

  // floor(x / 100) = (x * 5243) >> 19, exact for x below 2**14
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;
  // floor(x / 365) = (x * 5883517) >> 31, exact for x below 2**22
  localparam logic [22:0] Recip365      = 23'd5883517;
  localparam int unsigned Recip365Shift = 31;

  // elaboration only: days in the first n whole years
  function automatic int unsigned days_in_years(input int unsigned n);
    return n * 365 + n / 4 - n / 100 + n / 400;
  endfunction

  localparam logic [SumW-1:0] LastSerial = SumW'(days_in_years(MAX_YEAR - BASE_YEAR + 1));

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EST,
    CMD_MUL,
    CMD_SUM,
    CMD_STEP,
    CMD_LDIV,
    CMD_LREM,
    CMD_MON,
    CMD_FIN
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST,
    ST_MUL,
    ST_SUM,
    ST_STEP,
    ST_LDIV,
    ST_LREM,
    ST_MON,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic op;
    logic oor;
    logic loop_more;
    logic mon_more;
    logic out_free;
  } dp_sts_t;

  // days before the first of a month
  function automatic logic [DoyW-1:0] cum_days(input logic leap, input logic [MonthW-1:0] m);
    logic [DoyW-1:0] c;
    unique case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && m >= 4'd3 && m <= 4'd12) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic leap, input logic [MonthW-1:0] m);
    logic [DayW-1:0] l;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = leap ? 5'd29 : 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// File: rtl/gdconv_ctrl.sv
// Sequencer for the converter: walks the datapath through each conversion.
`timescale 1ns / 1ps
module gdconv_ctrl
  import gdconv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  output logic    req_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_e cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_EST;
      end
      ST_EST: begin
        if (!sts_i.op)     state_d = ST_MUL;
        else if (sts_i.oor) state_d = ST_FIN;
        else                state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = sts_i.op ? ST_STEP : ST_LDIV;
      // walk the year estimate down until the year start lies before the serial
      ST_STEP: state_d = sts_i.loop_more ? ST_MUL : ST_LDIV;
      ST_LDIV: state_d = ST_LREM;
      ST_LREM: state_d = sts_i.op ? ST_MON : ST_FIN;
      ST_MON:  state_d = sts_i.mon_more ? ST_MON : ST_FIN;
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = CMD_NONE;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) cmd_o = CMD_LOAD;
      end
      ST_EST:  cmd_o = sts_i.op ? CMD_EST : CMD_NONE;
      ST_MUL:  cmd_o = CMD_MUL;
      ST_SUM:  cmd_o = CMD_SUM;
      ST_STEP: cmd_o = CMD_STEP;
      ST_LDIV: cmd_o = CMD_LDIV;
      ST_LREM: cmd_o = CMD_LREM;
      ST_MON:  cmd_o = CMD_MON;
      ST_FIN: begin
        if (sts_i.out_free) cmd_o = CMD_FIN;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

// File: rtl/gdconv_dp.sv
// Datapath: year arithmetic, leap test, month search and the result register.
`timescale 1ns / 1ps
module gdconv_dp
  import gdconv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_e            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               op_i,
  input  logic [DayW-1:0]    day_i,
  input  logic [MonthW-1:0]  month_i,
  input  logic [YearW-1:0]   year_i,
  input  logic [SerialW-1:0] serial_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SerialW-1:0] serial_out_o,
  output logic [DayW-1:0]    day_out_o,
  output logic [MonthW-1:0]  month_out_o,
  output logic [YearW-1:0]   year_out_o,
  output status_e            status_o
);

  logic               op_q;
  logic               oor_q;
  logic [DayW-1:0]    day_q;
  logic [MonthW-1:0]  month_q;
  logic [YearW-1:0]   year_q;
  logic [SerialW-1:0] serial_q;
  logic [YearW-1:0]   n_q;
  logic [SumW-1:0]    p365_q;
  logic [7:0]         q100_q;
  logic [SumW-1:0]    dyrs_q;
  logic [7:0]         yq_q;
  logic               leap_q;
  logic [DoyW-1:0]    doy_q;
  logic [MonthW-1:0]  m_q;

  logic               out_valid_q;
  logic [SerialW-1:0] out_serial_q;
  logic [DayW-1:0]    out_day_q;
  logic [MonthW-1:0]  out_month_q;
  logic [YearW-1:0]   out_year_q;
  status_e            out_status_q;

  logic [44:0]        est_prod;
  logic [26:0]        nq_prod;
  logic [26:0]        yq_prod;
  logic [SumW-1:0]    p365;
  logic [SumW-1:0]    dyrs;
  logic [YearW-1:0]   rem100;
  logic               leap;
  logic               oor;
  logic               loop_more;
  logic               mon_more;
  logic               out_free;
  logic [SumW-1:0]    doy_diff;
  logic               date_ok;
  logic [SumW-1:0]    date_sum;
  logic [MonthW-1:0]  m_fin;
  logic [DoyW-1:0]    day_fin;

  assign est_prod = {23'd0, serial_q} * {22'd0, Recip365};
  assign nq_prod  = {13'd0, n_q} * {14'd0, Recip100};
  assign yq_prod  = {13'd0, year_q} * {14'd0, Recip100};
  assign p365     = {9'd0, n_q} * 23'd365;
  assign dyrs     = p365_q + {11'd0, n_q[YearW-1:2]} - {15'd0, q100_q} + {17'd0, q100_q[7:2]};
  assign rem100   = year_q - ({6'd0, yq_q} * 14'd100);
  assign leap     = ((year_q[1:0] == 2'd0) && (rem100 != '0))
                 || ((rem100 == '0) && (yq_q[1:0] == 2'd0));

  assign oor       = (serial_q == '0) || ({1'b0, serial_q} > LastSerial);
  assign loop_more = ({1'b0, serial_q} <= dyrs_q) && (n_q != '0);
  assign mon_more  = (m_q <= 4'd12) && (doy_q > cum_days(leap_q, m_q));
  assign out_free  = !out_valid_q || out_ready_i;
  assign doy_diff  = {1'b0, serial_q} - dyrs_q;

  always_comb begin
    date_ok = (year_q >= BaseYearW) && (year_q <= MaxYearW)
           && (month_q >= 4'd1) && (month_q <= 4'd12)
           && (day_q != '0) && (day_q <= month_len(leap_q, month_q));
    date_sum = dyrs_q + {14'd0, cum_days(leap_q, month_q)} + {18'd0, day_q};
    // a date past the serial width counts as invalid
    date_ok  = date_ok && !date_sum[SumW-1];
    m_fin    = m_q - 4'd1;
    day_fin  = doy_q - cum_days(leap_q, m_fin);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        op_q     <= op_i;
        day_q    <= day_i;
        month_q  <= month_i;
        year_q   <= year_i;
        serial_q <= serial_i;
        n_q      <= year_i - BaseYearW;
        m_q      <= 4'd2;
      end
      CMD_EST: begin
        n_q   <= est_prod[Recip365Shift +: YearW];
        oor_q <= oor;
      end
      CMD_MUL: begin
        p365_q <= p365;
        q100_q <= nq_prod[Recip100Shift +: 8];
      end
      CMD_SUM: dyrs_q <= dyrs;
      CMD_STEP: begin
        if (loop_more) begin
          n_q <= n_q - 14'd1;
        end else begin
          year_q <= BaseYearW + n_q;
          doy_q  <= doy_diff[DoyW-1:0];
        end
      end
      CMD_LDIV: yq_q <= yq_prod[Recip100Shift +: 8];
      CMD_LREM: leap_q <= leap;
      CMD_MON: begin
        if (mon_more) m_q <= m_q + 4'd1;
      end
      CMD_NONE, CMD_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_FIN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_FIN) begin
      out_serial_q <= '0;
      out_day_q    <= '0;
      out_month_q  <= '0;
      out_year_q   <= '0;
      if (!op_q) begin
        if (date_ok) begin
          out_serial_q <= date_sum[SerialW-1:0];
          out_status_q <= STATUS_OK;
        end else begin
          out_status_q <= STATUS_BAD_DATE;
        end
      end else if (oor_q) begin
        out_status_q <= STATUS_RANGE;
      end else begin
        out_day_q    <= day_fin[DayW-1:0];
        out_month_q  <= m_fin;
        out_year_q   <= year_q;
        out_status_q <= STATUS_OK;
      end
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.oor       = oor;
  assign sts_o.loop_more = loop_more;
  assign sts_o.mon_more  = mon_more;
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign serial_out_o = out_serial_q;
  assign day_out_o    = out_day_q;
  assign month_out_o  = out_month_q;
  assign year_out_o   = out_year_q;
  assign status_o     = out_status_q;

  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_FIN |=> out_valid_q)
    else $error("result register not loaded after finish");

  a_doy_in_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FIN) && op_q && !oor_q |-> (doy_q != '0) && (doy_q <= 9'd366))
    else $error("day of year out of range after year search");

  a_ok_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STATUS_OK) |-> ((out_serial_q != '0) != (out_month_q != '0)))
    else $error("good result carries both or neither of serial and date");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STATUS_RANGE)
      |-> (out_year_q == '0) && (out_month_q == '0) && (out_day_q == '0))
    else $error("out-of-range result carries a date");

endmodule

// File: rtl/gregorian_date_day_number_converter.sv
// Top level of the Gregorian date / day-number converter.
`timescale 1ns / 1ps
// Converts a day/month/year triple to a day number (1 January 1601 is day 1)
// and a day number back to a date. One request gives one result.
// Slave channel: tuser carries the op (0 date to number, 1 number to date),
// tdata the day, month, year and serial fields. Master channel: tdata carries
// serial_out, day_out, month_out and year_out, tuser the status.
// Requests are handled one at a time. Date to number steps from accept to the
// result register through an empty estimate slot, a multiply and a sum for the
// whole years, two steps of leap-year test, then the final add and check.
// Number to date runs the estimate, then k passes (1 to 7) of the year search
// loop, which steps the year estimate down through the shared multiply-and-sum
// unit, then the leap-year test and m steps (1 to 12) of the month search, then
// the final step. A serial out of range goes from the estimate straight to the
// final step. The sequencer returns to idle between requests.
// A new request is taken as soon as the previous one sits in the result
// register, even while that result waits for tready. If the receiver stalls
// with a result pending, the next conversion holds in its final step until
// the result register frees up. Reset empties the result register and
// returns the sequencer to idle; nothing else needs clearing.
module gregorian_date_day_number_converter
  import gdconv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // day[4:0], month[8:5], year[22:9], serial[44:23]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // serial_out[21:0], day_out[26:22], month_out[30:27],
                                      // year_out[44:31]
  output logic [1:0]  m_axis_tuser    // status
);

  dp_cmd_e            cmd;
  dp_sts_t            sts;
  logic [SerialW-1:0] serial_out;
  logic [DayW-1:0]    day_out;
  logic [MonthW-1:0]  month_out;
  logic [YearW-1:0]   year_out;
  status_e            status;

  gdconv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdconv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .day_i        (s_axis_tdata[4:0]),
    .month_i      (s_axis_tdata[8:5]),
    .year_i       (s_axis_tdata[22:9]),
    .serial_i     (s_axis_tdata[44:23]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .serial_out_o (serial_out),
    .day_out_o    (day_out),
    .month_out_o  (month_out),
    .year_out_o   (year_out),
    .status_o     (status)
  );

  assign m_axis_tdata = {3'd0, year_out, month_out, day_out, serial_out};
  assign m_axis_tuser = status;

endmodule
